[rtl/v3n_pkg.sv]
// Shared types for the vector normalization core.
`default_nettype none
package v3n_pkg;

  localparam int unsigned LANES = 3;
  localparam int unsigned UNIT_WIDTH = 32;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/v3n_prep.sv]
// Front stages: sign split, squares, sum of squares and scaled numerators.
`default_nettype none
module v3n_prep #(
  parameter int unsigned IN_WIDTH      = 32,
  parameter int unsigned OUT_FRAC_BITS = 30,
  parameter int unsigned RW            = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [IN_WIDTH-1:0]                    in_x,
  input  wire logic [IN_WIDTH-1:0]                    in_y,
  input  wire logic [IN_WIDTH-1:0]                    in_z,
  output v3n_pkg::ctl_t                               ctl,
  output logic [RW-1:0]                               s,
  output logic [v3n_pkg::LANES-1:0][RW-1:0]           r
);

  localparam int unsigned SW = 2 * IN_WIDTH;

  logic [v3n_pkg::LANES-1:0][IN_WIDTH-1:0] raw;
  logic [v3n_pkg::LANES-1:0][IN_WIDTH-1:0] mag;
  v3n_pkg::ctl_t                           ctl1;
  v3n_pkg::ctl_t                           ctl2;
  logic [v3n_pkg::LANES-1:0][SW-1:0]       sq;
  logic [SW+1:0]                           sum_next;

  assign raw = {in_z, in_y, in_x};

  always_ff @(posedge clk) begin
    for (int i = 0; i < v3n_pkg::LANES; i++) begin
      mag[i] <= raw[i][IN_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
    end
    ctl1.neg  <= {in_z[IN_WIDTH-1], in_y[IN_WIDTH-1], in_x[IN_WIDTH-1]};
    ctl1.zero <= 1'b0;
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < v3n_pkg::LANES; i++) begin
      sq[i] <= SW'(mag[i]) * SW'(mag[i]);
    end
    ctl2.neg  <= ctl1.neg;
    ctl2.zero <= (mag == '0);
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl1.valid;
    end
  end

  assign sum_next = (SW+2)'(sq[0]) + (SW+2)'(sq[1]) + (SW+2)'(sq[2]);

  always_ff @(posedge clk) begin
    s <= RW'(sum_next);
    for (int i = 0; i < v3n_pkg::LANES; i++) begin
      r[i] <= RW'(sq[i]) << (2 * OUT_FRAC_BITS);
    end
    ctl.neg  <= ctl2.neg;
    ctl.zero <= ctl2.zero;
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl2.valid;
    end
  end

endmodule
`default_nettype wire

[rtl/v3n_cell.sv]
// One quotient bit of the restoring normalize, for all three lanes.
`default_nettype none
module v3n_cell #(
  parameter int unsigned IN_WIDTH      = 32,
  parameter int unsigned OUT_FRAC_BITS = 30,
  parameter int unsigned BIT           = 0,
  parameter int unsigned RW            = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3,
  parameter int unsigned QW            = OUT_FRAC_BITS + 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  v3n_pkg::ctl_t                               ctl_in,
  input  wire logic [RW-1:0]                          s_in,
  input  wire logic [v3n_pkg::LANES-1:0][RW-1:0]      r_in,
  input  wire logic [v3n_pkg::LANES-1:0][RW-1:0]      p_in,
  input  wire logic [v3n_pkg::LANES-1:0][QW-1:0]      q_in,
  output v3n_pkg::ctl_t                               ctl_out,
  output logic [RW-1:0]                               s_out,
  output logic [v3n_pkg::LANES-1:0][RW-1:0]           r_out,
  output logic [v3n_pkg::LANES-1:0][RW-1:0]           p_out,
  output logic [v3n_pkg::LANES-1:0][QW-1:0]           q_out
);

  logic [v3n_pkg::LANES-1:0][RW-1:0] t;
  logic [v3n_pkg::LANES-1:0]         take;
  logic [v3n_pkg::LANES-1:0][RW-1:0] r_next;
  logic [v3n_pkg::LANES-1:0][RW-1:0] p_next;
  logic [v3n_pkg::LANES-1:0][QW-1:0] q_next;

  always_comb begin
    for (int i = 0; i < v3n_pkg::LANES; i++) begin
      t[i]    = (p_in[i] << (BIT + 1)) + (s_in << (2 * BIT));
      take[i] = (t[i] <= r_in[i]);
      r_next[i] = take[i] ? (r_in[i] - t[i]) : r_in[i];
      p_next[i] = take[i] ? (p_in[i] + (s_in << BIT)) : p_in[i];
      q_next[i] = q_in[i];
      q_next[i][BIT] = take[i];
    end
  end

  always_ff @(posedge clk) begin
    s_out         <= s_in;
    r_out         <= r_next;
    p_out         <= p_next;
    q_out         <= q_next;
    ctl_out.neg   <= ctl_in.neg;
    ctl_out.zero  <= ctl_in.zero;
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

endmodule
`default_nettype wire

[rtl/vec3_normalize_core.sv]
// Top level of the pipelined three-component vector normalizer.
//
//   port group            dir  meaning
//   start in_x in_y in_z  in   request: Q16.16 vector, taken when start is high
//   busy                  out  always low, a request is taken every cycle
//   done unit_* zero_len  out  result: Q2.30 unit vector for one cycle
//
// One request per cycle; the stages, in order, are:
// three front stages, one cell per quotient bit, one output register.
// The cell row sets the latency; each cell does one wide compare and subtract per lane.
// Synchronous reset clears the valid bits of every stage; data is not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module vec3_normalize_core #(
  parameter int unsigned IN_WIDTH      = 32,
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic [IN_WIDTH-1:0]                      in_x,
  input  wire logic [IN_WIDTH-1:0]                      in_y,
  input  wire logic [IN_WIDTH-1:0]                      in_z,
  output logic                                          done,
  output logic signed [v3n_pkg::UNIT_WIDTH-1:0]         unit_x,
  output logic signed [v3n_pkg::UNIT_WIDTH-1:0]         unit_y,
  output logic signed [v3n_pkg::UNIT_WIDTH-1:0]         unit_z,
  output logic                                          zero_length
);

  localparam int unsigned RW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3;
  localparam int unsigned QW = OUT_FRAC_BITS + 1;
  localparam int unsigned NC = OUT_FRAC_BITS + 1;
  localparam int unsigned EW = 64;

  v3n_pkg::ctl_t                     c_st [NC+1];
  logic [RW-1:0]                     s_st [NC+1];
  logic [v3n_pkg::LANES-1:0][RW-1:0] r_st [NC+1];
  logic [v3n_pkg::LANES-1:0][RW-1:0] p_st [NC+1];
  logic [v3n_pkg::LANES-1:0][QW-1:0] q_st [NC+1];

  logic [v3n_pkg::LANES-1:0][EW-1:0] ext;
  logic [v3n_pkg::LANES-1:0][EW-1:0] sgn;

  assign busy = 1'b0;

  v3n_prep #(
    .IN_WIDTH      (IN_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .RW            (RW)
  ) u_prep (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .in_x  (in_x),
    .in_y  (in_y),
    .in_z  (in_z),
    .ctl   (c_st[0]),
    .s     (s_st[0]),
    .r     (r_st[0])
  );

  assign p_st[0] = '0;
  assign q_st[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    v3n_cell #(
      .IN_WIDTH      (IN_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .BIT           (OUT_FRAC_BITS - k),
      .RW            (RW),
      .QW            (QW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (c_st[k]),
      .s_in    (s_st[k]),
      .r_in    (r_st[k]),
      .p_in    (p_st[k]),
      .q_in    (q_st[k]),
      .ctl_out (c_st[k+1]),
      .s_out   (s_st[k+1]),
      .r_out   (r_st[k+1]),
      .p_out   (p_st[k+1]),
      .q_out   (q_st[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < v3n_pkg::LANES; i++) begin
      ext[i] = EW'(q_st[NC][i]);
      if (c_st[NC].zero) begin
        sgn[i] = '0;
      end else if (c_st[NC].neg[i]) begin
        sgn[i] = ~ext[i] + 1'b1;
      end else begin
        sgn[i] = ext[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    unit_x      <= sgn[0][v3n_pkg::UNIT_WIDTH-1:0];
    unit_y      <= sgn[1][v3n_pkg::UNIT_WIDTH-1:0];
    unit_z      <= sgn[2][v3n_pkg::UNIT_WIDTH-1:0];
    zero_length <= c_st[NC].zero;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_st[NC].valid;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for vec3_normalize_core: directed and random vectors checked against a predictor.
`default_nettype none
module tb;

  localparam int FRAC = 30;
  localparam int LAT = 35;
  localparam longint LIMIT = 400000;
  localparam int NRAND = 1150;

  typedef struct {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic               zl;
  } unit_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    unit_t       res;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [31:0] in_x, in_y, in_z;
  logic done;
  logic signed [31:0] unit_x, unit_y, unit_z;
  logic zero_length;

  unit_t pending[$];
  int errors;
  int n_sent;
  int n_zero;
  int n_done;
  longint cycles;

  vec3_normalize_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .zero_length(zero_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag_of(logic [31:0] v);
    return v[31] ? 64'(-$signed({32'hFFFF_FFFF, v})) : 64'(v);
  endfunction

  // largest q with q*q*S <= m*m*2^(2F)
  function automatic logic [31:0] unit_quot(logic [63:0] m, logic [255:0] s);
    logic [255:0] num;
    logic [255:0] c;
    logic [255:0] q;
    num = (256'(m) * 256'(m)) << (2 * FRAC);
    q = '0;
    for (int b = FRAC; b >= 0; b--) begin
      c = q | (256'(1) << b);
      if (c * c * s <= num) q = c;
    end
    return q[31:0];
  endfunction

  function automatic unit_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    unit_t r;
    logic [63:0] mx, my, mz;
    logic [255:0] s;
    logic [31:0] qx, qy, qz;
    mx = mag_of(x);
    my = mag_of(y);
    mz = mag_of(z);
    s = 256'(mx) * 256'(mx) + 256'(my) * 256'(my) + 256'(mz) * 256'(mz);
    if (s == 0) begin
      r = '{32'sd0, 32'sd0, 32'sd0, 1'b1};
      return r;
    end
    qx = unit_quot(mx, s);
    qy = unit_quot(my, s);
    qz = unit_quot(mz, s);
    r.ux = x[31] ? -qx : qx;
    r.uy = y[31] ? -qy : qy;
    r.uz = z[31] ? -qz : qz;
    r.zl = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time, unit_x, unit_y, unit_z,
                 zero_length);
        errors++;
      end else begin
        unit_t e;
        e = pending.pop_front();
        if (e.ux !== unit_x) begin
          $display("%0t: unit_x expected %h actual %h", $time, e.ux, unit_x);
          errors++;
        end
        if (e.uy !== unit_y) begin
          $display("%0t: unit_y expected %h actual %h", $time, e.uy, unit_y);
          errors++;
        end
        if (e.uz !== unit_z) begin
          $display("%0t: unit_z expected %h actual %h", $time, e.uz, unit_z);
          errors++;
        end
        if (e.zl !== zero_length) begin
          $display("%0t: zero_length expected %b actual %b", $time, e.zl, zero_length);
          errors++;
        end
        n_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed, unit_t res);
    unit_t e;
    e = normalize(x, y, z);
    if (typed && (e.ux !== res.ux || e.uy !== res.uy || e.uz !== res.uz ||
                  e.zl !== res.zl)) begin
      $display("%0t: predictor expected %p actual %p", $time, res, e);
      errors++;
    end
    start <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(e);
    n_sent++;
    if (e.zl) n_zero++;
    @(negedge clk);
  endtask

  task automatic pause(bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($signed($urandom_range(16)) - 8);
      2: return '0;
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  localparam logic [31:0] P1 = 32'sd1 <<< FRAC;
  localparam logic [31:0] N1 = -(32'sd1 <<< FRAC);

  row_t dirs[] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, '{0, 0, 0, 1'b1}},
    '{32'h0001_0000, 32'h0, 32'h0, 1'b1, '{P1, 0, 0, 1'b0}},
    '{32'h0, 32'hFFFF_0000, 32'h0, 1'b1, '{0, N1, 0, 1'b0}},
    '{32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{0, 0, P1, 1'b0}},
    '{32'h8000_0000, 32'h0, 32'h0, 1'b1, '{N1, 0, 0, 1'b0}},
    '{32'h0, 32'h8000_0000, 32'h0, 1'b1, '{0, N1, 0, 1'b0}},
    '{32'h0, 32'h0, 32'h0000_0001, 1'b1, '{0, 0, P1, 1'b0}},
    '{32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, '{0, 0, N1, 1'b0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'h0003_0000, 32'h0004_0000, 32'h0, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 1'b0, '{0, 0, 0, 1'b0}},
    '{32'h0, 32'h0, 32'h0, 1'b1, '{0, 0, 0, 1'b1}}
  };

  initial begin
    errors = 0;
    n_sent = 0;
    n_zero = 0;
    n_done = 0;
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dirs[i]) begin
      send(dirs[i].x, dirs[i].y, dirs[i].z, dirs[i].typed, dirs[i].res);
      pause(1'b0);
    end
    for (int k = 0; k < NRAND; k++) begin
      if (k == NRAND / 2) begin
        start <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
      end
      send(rand_comp(), rand_comp(), rand_comp(), 1'b0, '{0, 0, 0, 1'b0});
      pause(k >= 300 && k < 500);
    end
    start <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    $display("sent %0d vectors (%0d zero length), checked %0d results", n_sent, n_zero,
             n_done);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/v3n_pkg.sv
rtl/v3n_prep.sv
rtl/v3n_cell.sv
rtl/vec3_normalize_core.sv
tb/tb.sv
